>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion with asynchronous reset disable.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assertion that also runs during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

>>> rtl/htlp_pkg.sv
// Package for the linear probing hash table: constants, codes and types.
`timescale 1ns / 1ps
`default_nettype none
package htlp_pkg;
  localparam int unsigned TableSlots = 64;
  localparam int unsigned KeyBytes   = 8;
  localparam int unsigned ValueBits  = 32;
  localparam int unsigned KeyW       = 64;
  localparam int unsigned InValW     = 32;
  localparam int unsigned HashW      = 32;

  typedef enum logic [1:0] {
    ModeInsert = 2'd0,
    ModeLookup = 2'd1,
    ModeRemove = 2'd2,
    ModeNone   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusMissing = 2'd1,
    StatusDup     = 2'd2,
    StatusFull    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SlotEmpty   = 2'd0,
    SlotUsed    = 2'd1,
    SlotDeleted = 2'd2,
    SlotRsvd    = 2'd3
  } slot_e;

  // hash unit control / status
  typedef struct packed {
    logic start;
  } hash_ctl_t;

  typedef struct packed {
    logic done;
  } hash_sts_t;
endpackage
`default_nettype wire

>>> rtl/htlp_stream_if.sv
// Valid/ready channel interfaces for request and response words.
`timescale 1ns / 1ps
`default_nettype none
interface htlp_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  mode;
  logic [htlp_pkg::KeyW-1:0]   key;
  logic [htlp_pkg::InValW-1:0] value;
  modport source (output valid, mode, key, value, input ready);
  modport sink   (input valid, mode, key, value, output ready);
endinterface

interface htlp_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] value_out;
  logic [6:0]  entry_count;
  modport source (output valid, status, value_out, entry_count, input ready);
  modport sink   (input valid, status, value_out, entry_count, output ready);
endinterface
`default_nettype wire

>>> rtl/hash_table_linear_probe.sv
// Top level of the linear probing hash table.
// Each request (insert, lookup, remove) first passes through a byte-serial hash
// unit (one byte per cycle, three finish steps, then a registered done flag),
// then probes slots in a read and a compare state each (registered read of the slot
// RAMs and slot state, then compare), then writes, presents the response word and
// returns to idle before the next word is taken. An unused mode or an insert into
// a full table skips hashing and goes straight to the response. One request is in
// flight at a time; in_ready is low until its response word has been taken. Slot
// states live in flip-flops cleared by reset; keys, values and hashes are in RAM.
`timescale 1ns / 1ps
`default_nettype none
module hash_table_linear_probe #(
  parameter int unsigned TableSlots = htlp_pkg::TableSlots,
  parameter int unsigned KeyBytes   = htlp_pkg::KeyBytes,
  parameter int unsigned ValueBits  = htlp_pkg::ValueBits
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  htlp_req_if.sink   req_i,
  htlp_rsp_if.source rsp_o
);
  localparam int unsigned AW = $clog2(TableSlots);
  localparam int unsigned CW = $clog2(TableSlots + 1);
  localparam int unsigned KM = KeyBytes * 8;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StHash  = 6'b000010,
    StRead  = 6'b000100,
    StCmp   = 6'b001000,
    StWrite = 6'b010000,
    StResp  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  htlp_pkg::slot_e slot_st_q [TableSlots];
  logic [CW-1:0] occ_q, occ_d;
  logic [1:0] mode_q;
  logic [63:0] key_q;
  logic [ValueBits-1:0] val_q;
  logic [AW-1:0] pos_q, pos_d;
  logic [CW-1:0] n_q, n_d;
  logic          free_v_q, free_v_d;
  logic [AW-1:0] free_q, free_d;
  logic [1:0]    status_q, status_d;
  logic [ValueBits-1:0] vout_q, vout_d;
  logic          hit_q, hit_d;
  logic [AW-1:0] wr_slot_q, wr_slot_d;
  logic [31:0] hash;
  htlp_pkg::hash_ctl_t hctl;
  htlp_pkg::hash_sts_t hsts;
  logic we;
  logic [63:0] rkey;
  logic [ValueBits-1:0] rval;
  logic [31:0] rhash;
  logic [AW-1:0] ram_addr;
  logic [63:0] key_m;

  always_comb begin
    key_m = req_i.key;
    if (KM < 64) key_m = req_i.key & ((64'd1 << (KM % 64)) - 64'd1);
  end

  htlp_hash #(.KeyBytes(KeyBytes)) u_hash (
    .clk_i, .rst_ni, .ctl_i(hctl), .key_i(key_m), .sts_o(hsts), .hash_o(hash)
  );

  assign ram_addr = (state_q == StWrite) ? wr_slot_q : pos_q;
  assign we = (state_q == StWrite) && (mode_q == htlp_pkg::ModeInsert) &&
              !hit_q && free_v_q;

  htlp_ram #(.Width(64), .Depth(TableSlots)) u_key (
    .clk_i, .we_i(we), .addr_i(ram_addr), .wdata_i(key_q), .rdata_o(rkey));
  htlp_ram #(.Width(ValueBits), .Depth(TableSlots)) u_val (
    .clk_i, .we_i(we), .addr_i(ram_addr), .wdata_i(val_q), .rdata_o(rval));
  htlp_ram #(.Width(32), .Depth(TableSlots)) u_hsh (
    .clk_i, .we_i(we), .addr_i(ram_addr), .wdata_i(hash), .rdata_o(rhash));

  assign req_i.ready = (state_q == StIdle);
  assign hctl.start = req_i.valid && req_i.ready &&
                      ((req_i.mode == htlp_pkg::ModeInsert &&
                        occ_q != CW'(TableSlots)) ||
                       req_i.mode == htlp_pkg::ModeLookup ||
                       req_i.mode == htlp_pkg::ModeRemove);

  // slot state read in step with the RAMs
  htlp_pkg::slot_e cur_q;

  always_comb begin
    state_d = state_q; occ_d = occ_q; pos_d = pos_q; n_d = n_q;
    free_v_d = free_v_q; free_d = free_q; status_d = status_q;
    vout_d = vout_q; hit_d = hit_q; wr_slot_d = wr_slot_q;
    unique case (state_q)
      StIdle: begin
        if (req_i.valid) begin
          status_d = htlp_pkg::StatusOk;
          vout_d = '0; hit_d = 1'b0; free_v_d = 1'b0; n_d = '0;
          if (hctl.start) state_d = StHash;
          else begin
            if (req_i.mode == htlp_pkg::ModeInsert) status_d = htlp_pkg::StatusFull;
            state_d = StResp;
          end
        end
      end
      StHash: if (hsts.done) begin
        pos_d = hash[AW-1:0];
        state_d = StRead;
      end
      StRead: state_d = StCmp;
      StCmp: begin
        state_d = StRead;
        if (cur_q == htlp_pkg::SlotEmpty) begin
          if (!free_v_q) begin free_v_d = 1'b1; free_d = pos_q; end
          state_d = StWrite;
        end else if (cur_q == htlp_pkg::SlotUsed && rhash == hash && rkey == key_q) begin
          hit_d = 1'b1; wr_slot_d = pos_q; state_d = StWrite;
        end else if (cur_q == htlp_pkg::SlotDeleted && !free_v_q) begin
          free_v_d = 1'b1; free_d = pos_q;
        end
        if (state_d == StRead) begin
          pos_d = pos_q + 1'b1;
          n_d = n_q + 1'b1;
          if (n_q == CW'(TableSlots - 1)) state_d = StWrite;
        end
        if (state_d == StWrite && mode_q == htlp_pkg::ModeInsert && !hit_d)
          wr_slot_d = free_v_d ? free_d : pos_q;
      end
      StWrite: begin
        state_d = StResp;
        if (mode_q == htlp_pkg::ModeInsert) begin
          if (hit_q) status_d = htlp_pkg::StatusDup;
          else if (!free_v_q) status_d = htlp_pkg::StatusFull;
          else occ_d = occ_q + 1'b1;
        end else if (!hit_q) status_d = htlp_pkg::StatusMissing;
        else begin
          vout_d = rval;
          if (mode_q == htlp_pkg::ModeRemove && occ_q != '0) occ_d = occ_q - 1'b1;
        end
      end
      StResp: if (rsp_o.ready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // the write cycle reads the hit slot's value too (same address)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      occ_q <= '0;
      for (int i = 0; i < TableSlots; i++) slot_st_q[i] <= htlp_pkg::SlotEmpty;
    end else begin
      state_q <= state_d;
      occ_q <= occ_d;
      if (state_q == StWrite) begin
        if (we && !hit_q && free_v_q) slot_st_q[wr_slot_q] <= htlp_pkg::SlotUsed;
        if (mode_q == htlp_pkg::ModeRemove && hit_q)
          slot_st_q[wr_slot_q] <= htlp_pkg::SlotDeleted;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      mode_q <= req_i.mode;
      key_q <= key_m;
      val_q <= ValueBits'(req_i.value);
    end
    cur_q <= slot_st_q[pos_q];
    pos_q <= pos_d; n_q <= n_d; free_v_q <= free_v_d; free_q <= free_d;
    status_q <= status_d; vout_q <= vout_d; hit_q <= hit_d; wr_slot_q <= wr_slot_d;
  end

  logic [63:0] vout_w;
  assign vout_w = 64'(vout_q);
  assign rsp_o.valid = (state_q == StResp);
  assign rsp_o.status = status_q;
  assign rsp_o.value_out = vout_w[31:0];
  assign rsp_o.entry_count = 7'(occ_q);
endmodule
`default_nettype wire

>>> rtl/htlp_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module htlp_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

>>> rtl/htlp_hash.sv
// One-at-a-time hash unit, one key byte per cycle, then three finish steps.
`timescale 1ns / 1ps
`default_nettype none
module htlp_hash #(
  parameter int unsigned KeyBytes = htlp_pkg::KeyBytes
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire htlp_pkg::hash_ctl_t       ctl_i,
  input  wire logic [htlp_pkg::KeyW-1:0] key_i,
  output htlp_pkg::hash_sts_t            sts_o,
  output logic [htlp_pkg::HashW-1:0]     hash_o
);
  localparam int unsigned CntW = $clog2(KeyBytes + 4);
  localparam logic [CntW-1:0] LastByte = CntW'(KeyBytes - 1);
  localparam logic [CntW-1:0] Fin0 = CntW'(KeyBytes);
  localparam logic [CntW-1:0] Fin1 = CntW'(KeyBytes + 1);
  localparam logic [CntW-1:0] Fin2 = CntW'(KeyBytes + 2);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [31:0]     h_q, h_d, t;
  logic [63:0]     key_q, key_d;
  logic            done_q, done_d;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    h_d    = h_q;
    key_d  = key_q;
    done_d = 1'b0;
    t      = '0;
    if (ctl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      h_d    = '0;
      key_d  = key_i;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q <= LastByte) begin
        t     = h_q + {24'd0, key_q[7:0]};
        t     = t + (t << 10);
        h_d   = t ^ (t >> 6);
        key_d = key_q >> 8;
      end else if (cnt_q == Fin0) begin
        h_d = h_q + (h_q << 3);
      end else if (cnt_q == Fin1) begin
        h_d = h_q ^ (h_q >> 11);
      end else if (cnt_q == Fin2) begin
        h_d    = h_q + (h_q << 15);
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q   <= h_d;
    key_q <= key_d;
  end

  assign sts_o.done = done_q;
  assign hash_o     = h_q;
endmodule
`default_nettype wire

>>> rtl/htlp_checker.sv
// Port-level checker for the hash table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module htlp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [1:0]  status_i,
  input wire logic [31:0] value_out_i,
  input wire logic [6:0]  entry_count_i
);
  logic req_acc;
  logic rsp_wait;
  logic ins_fail;

  assign req_acc  = in_valid_i && in_ready_i;
  assign rsp_wait = out_valid_i && !out_ready_i;
  // duplicate and full only come from inserts
  assign ins_fail = out_valid_i && (status_i == htlp_pkg::StatusDup ||
                                    status_i == htlp_pkg::StatusFull);

  `ASSERT_CLK(a_one_inflight, clk_i, rst_ni, !(in_ready_i && out_valid_i), "busy overlap")
  `ASSERT_CLK(a_accept_blocks, clk_i, rst_ni, req_acc |=> !in_ready_i, "ready after accept")
  `ASSERT_CLK(a_resp_hold, clk_i, rst_ni, rsp_wait |=> (out_valid_i && $stable(status_i)), "resp dropped")
  `ASSERT_CLK(a_insert_zero, clk_i, rst_ni, ins_fail |-> value_out_i == 32'd0, "value on failed insert")
  `ASSERT_CLK(a_count_max, clk_i, rst_ni, entry_count_i <= 7'd64, "count overflow")
endmodule

bind hash_table_linear_probe htlp_checker u_htlp_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid_i(req_i.valid), .in_ready_i(req_i.ready),
  .out_valid_i(rsp_o.valid), .out_ready_i(rsp_o.ready),
  .status_i(rsp_o.status), .value_out_i(rsp_o.value_out),
  .entry_count_i(rsp_o.entry_count)
);
`default_nettype wire
